// ----- rtl/pst_pkg.sv -----
// shared widths and types for the planar steer pipeline
`default_nettype none
package pst_pkg;

   localparam int CoordW = 32;  // signed coordinate width
   localparam int MagW   = 32;  // magnitude of one coordinate difference
   localparam int StepW  = 31;  // step length register width
   localparam int SqW    = 65;  // dx*dx + dy*dy
   localparam int ProdW  = 63;  // step * magnitude
   localparam int RootW  = 64;  // floor(sqrt(sq * 2^60))
   localparam int RemW   = 66;  // square root partial remainder
   localparam int RadW   = 2 * RootW;
   localparam int DistExtra = 30;  // fractional bits of the root
   localparam int DivW   = 64;  // divisor 2*root
   localparam int QuoW   = 34;  // quotient bits kept
   localparam int NumW   = 95;  // dividend step*mag*2^31 + root
   localparam int OffW   = 34;  // signed offset

   // item context carried alongside the square root
   typedef struct packed {
      logic signed [CoordW-1:0] px;
      logic signed [CoordW-1:0] py;
      logic signed [CoordW-1:0] sx;
      logic signed [CoordW-1:0] sy;
      logic                     negx;
      logic                     negy;
      logic                     near;
      logic [ProdW-1:0]         prodx;
      logic [ProdW-1:0]         prody;
   } ctx_type;

endpackage
`default_nettype wire

// ----- rtl/pst_ifs.sv -----
// valid/ready channel interfaces of the planar steer block
`default_nettype none
interface pst_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] parent_x;
   logic signed [31:0] parent_y;
   logic signed [31:0] sample_x;
   logic signed [31:0] sample_y;
   modport source (output valid, parent_x, parent_y, sample_x, sample_y, input ready);
   modport sink   (input valid, parent_x, parent_y, sample_x, sample_y, output ready);
endinterface

interface pst_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic               clipped;
   modport source (output valid, new_x, new_y, clipped, input ready);
   modport sink   (input valid, new_x, new_y, clipped, output ready);
endinterface

interface pst_csr_if;
   logic        valid;
   logic        ready;
   logic [30:0] step_length;
   modport source (output valid, step_length, input ready);
   modport sink   (input valid, step_length, output ready);
endinterface
`default_nettype wire

// ----- rtl/pst_isqrt.sv -----
// pipelined integer square root, one result bit per stage
`default_nettype none
module pst_isqrt
   import pst_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [SqW-1:0]   in_q,
   input  wire ctx_type          in_ctx,
   output logic                  out_valid,
   output logic [RootW-1:0]      out_root,
   output ctx_type               out_ctx
);

   logic                 v_ff    [RootW];
   logic [RemW-1:0]      rem_ff  [RootW];
   logic [RootW-1:0]     root_ff [RootW];
   logic [SqW-1:0]       q_ff    [RootW];
   ctx_type              ctx_ff  [RootW];

   for (genvar k = 0; k < RootW; k++) begin : g_stage
      localparam int Pair = RootW - 1 - k;
      logic              v_prev;
      logic [RemW-1:0]   rem_prev;
      logic [RootW-1:0]  root_prev;
      logic [SqW-1:0]    q_prev;
      ctx_type           ctx_prev;
      logic [RadW-1:0]   rad;
      logic [RemW+1:0]   rsh;
      logic [RemW+1:0]   trial;
      logic [RemW+1:0]   diff;
      logic              ge;
      logic [RemW-1:0]   rem_in;
      logic [RootW-1:0]  root_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign q_prev    = in_q;
         assign ctx_prev  = in_ctx;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign ctx_prev  = ctx_ff[k-1];
      end

      // radicand is the squared distance scaled by 2^60
      assign rad     = {3'b000, q_prev, {(2 * DistExtra){1'b0}}};
      assign rsh     = {rem_prev, rad[2*Pair+1 -: 2]};
      assign trial   = {2'b00, root_prev, 2'b01};
      assign diff    = rsh - trial;
      assign ge      = (rsh >= trial);
      assign rem_in  = ge ? diff[RemW-1:0] : rsh[RemW-1:0];
      assign root_in = {root_prev[RootW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            q_ff[k]    <= q_prev;
            ctx_ff[k]  <= ctx_prev;
         end
      end
   end

   assign out_valid = v_ff[RootW-1];
   assign out_root  = root_ff[RootW-1];
   assign out_ctx   = ctx_ff[RootW-1];

endmodule
`default_nettype wire

// ----- rtl/planar_steer_toward_sample.sv -----
// top level of the planar steer block: clips a sample to a step from its parent
//
// channel   dir   beat contents
// req_ch    in    parent_x, parent_y, sample_x, sample_y (signed Q15.16)
// rsp_ch    out   new_x, new_y (signed, saturated), clipped
// csr_ch    in    step_length (unsigned Q15.16, 31 bits)
//
// one beat in and one beat out per cycle while rsp_ch does not stall; 106 register stages
// lie between request beat and response beat: 5 ahead of the root,
// the 64 stage square root, one dividend stage, 34 quotient stages and two at the end
// reset (synchronous) empties the pipe and loads step_length with 1.0
// a stall on rsp_ch freezes the whole pipe except that a bubble just ahead of
// the output register still fills, so req_ch stays open while a result waits until that bubble is filled
`default_nettype none
module planar_steer_toward_sample
   import pst_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pst_req_if.sink    req_ch,
   pst_rsp_if.source  rsp_ch,
   pst_csr_if.sink    csr_ch
);

   typedef struct packed {
      logic signed [CoordW-1:0] px;
      logic signed [CoordW-1:0] py;
      logic signed [CoordW-1:0] sx;
      logic signed [CoordW-1:0] sy;
      logic                     negx;
      logic                     negy;
      logic                     near;
      logic                     zero;
      logic [DivW-1:0]          d;
      logic [QuoW-1:0]          lowx;
      logic [QuoW-1:0]          lowy;
   } dv_type;

   // ---------------- step length register ----------------
   logic [StepW-1:0]     step_ff;
   logic [2*StepW-1:0]   step_sq_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= StepW'(1) << COORD_FRAC_BITS;
      end else if (csr_ch.valid) begin
         step_ff <= csr_ch.step_length;
      end
   end

   // square of the step for the near test; config must only move while idle, which the block does not enforce
   always_ff @(posedge clock) begin
      step_sq_ff <= step_ff * step_ff;
   end

   // ---------------- stall control ----------------
   logic rsp_v_ff;
   logic f1_v_ff;
   logic out_en;
   logic front_en;

   assign out_en       = !rsp_v_ff || rsp_ch.ready;
   // everything ahead of the output moves unless the last stage is blocked
   assign front_en     = out_en || !f1_v_ff;
   assign req_ch.ready = front_en;

   // ---------------- stage 0: input register ----------------
   logic                     s0_v_ff;
   logic signed [CoordW-1:0] s0_px_ff, s0_py_ff, s0_sx_ff, s0_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (front_en) begin
         s0_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s0_px_ff <= req_ch.parent_x;
         s0_py_ff <= req_ch.parent_y;
         s0_sx_ff <= req_ch.sample_x;
         s0_sy_ff <= req_ch.sample_y;
      end
   end

   // ---------------- stage 1: differences and magnitudes ----------------
   logic [CoordW:0]          dx_in, dy_in, adx_w, ady_w;
   logic                     s1_v_ff;
   logic signed [CoordW-1:0] s1_px_ff, s1_py_ff, s1_sx_ff, s1_sy_ff;
   logic [MagW-1:0]          s1_adx_ff, s1_ady_ff;
   logic                     s1_negx_ff, s1_negy_ff;

   assign dx_in = {s0_sx_ff[CoordW-1], s0_sx_ff} - {s0_px_ff[CoordW-1], s0_px_ff};
   assign dy_in = {s0_sy_ff[CoordW-1], s0_sy_ff} - {s0_py_ff[CoordW-1], s0_py_ff};
   assign adx_w = dx_in[CoordW] ? ((CoordW+1)'(0) - dx_in) : dx_in;
   assign ady_w = dy_in[CoordW] ? ((CoordW+1)'(0) - dy_in) : dy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (front_en) begin
         s1_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s1_px_ff   <= s0_px_ff;
         s1_py_ff   <= s0_py_ff;
         s1_sx_ff   <= s0_sx_ff;
         s1_sy_ff   <= s0_sy_ff;
         s1_adx_ff  <= adx_w[MagW-1:0];
         s1_ady_ff  <= ady_w[MagW-1:0];
         s1_negx_ff <= dx_in[CoordW];
         s1_negy_ff <= dy_in[CoordW];
      end
   end

   // ---------------- stage 2: squares and step products ----------------
   logic [2*MagW-1:0]        sqx_in, sqy_in;
   logic [ProdW-1:0]         prodx_in, prody_in;
   logic                     s2_v_ff;
   logic signed [CoordW-1:0] s2_px_ff, s2_py_ff, s2_sx_ff, s2_sy_ff;
   logic [MagW-1:0]          s2_adx_ff, s2_ady_ff;
   logic                     s2_negx_ff, s2_negy_ff;
   logic [2*MagW-1:0]        s2_sqx_ff, s2_sqy_ff;
   logic [ProdW-1:0]         s2_prodx_ff, s2_prody_ff;

   assign sqx_in   = s1_adx_ff * s1_adx_ff;
   assign sqy_in   = s1_ady_ff * s1_ady_ff;
   assign prodx_in = step_ff * s1_adx_ff;
   assign prody_in = step_ff * s1_ady_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (front_en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s2_px_ff    <= s1_px_ff;
         s2_py_ff    <= s1_py_ff;
         s2_sx_ff    <= s1_sx_ff;
         s2_sy_ff    <= s1_sy_ff;
         s2_adx_ff   <= s1_adx_ff;
         s2_ady_ff   <= s1_ady_ff;
         s2_negx_ff  <= s1_negx_ff;
         s2_negy_ff  <= s1_negy_ff;
         s2_sqx_ff   <= sqx_in;
         s2_sqy_ff   <= sqy_in;
         s2_prodx_ff <= prodx_in;
         s2_prody_ff <= prody_in;
      end
   end

   // ---------------- stage 3: squared distance ----------------
   logic [SqW-1:0]           q_in;
   logic                     small_in;
   logic                     s3_v_ff;
   logic [SqW-1:0]           s3_q_ff;
   logic                     s3_small_ff;
   ctx_type                  s3_ctx_ff;

   assign q_in     = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
   assign small_in = ({1'b0, step_ff} > s2_adx_ff) && ({1'b0, step_ff} > s2_ady_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (front_en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s3_q_ff         <= q_in;
         s3_small_ff     <= small_in;
         s3_ctx_ff.px    <= s2_px_ff;
         s3_ctx_ff.py    <= s2_py_ff;
         s3_ctx_ff.sx    <= s2_sx_ff;
         s3_ctx_ff.sy    <= s2_sy_ff;
         s3_ctx_ff.negx  <= s2_negx_ff;
         s3_ctx_ff.negy  <= s2_negy_ff;
         s3_ctx_ff.near  <= 1'b0;
         s3_ctx_ff.prodx <= s2_prodx_ff;
         s3_ctx_ff.prody <= s2_prody_ff;
      end
   end

   // ---------------- stage 4: near test ----------------
   ctx_type                  ctx4_in;
   logic                     s4_v_ff;
   logic [SqW-1:0]           s4_q_ff;
   ctx_type                  s4_ctx_ff;

   // inside the step circle: return the sample as is
   always_comb begin
      ctx4_in      = s3_ctx_ff;
      ctx4_in.near = s3_small_ff && (s3_q_ff < {3'b000, step_sq_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (front_en) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s4_q_ff   <= s3_q_ff;
         s4_ctx_ff <= ctx4_in;
      end
   end

   // ---------------- square root: distance with 30 fraction bits ----------------
   logic             sq_v;
   logic [RootW-1:0] sq_root;
   ctx_type          sq_ctx;

   pst_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (front_en),
      .in_valid  (s4_v_ff),
      .in_q      (s4_q_ff),
      .in_ctx    (s4_ctx_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_ctx   (sq_ctx)
   );

   // ---------------- dividend setup ----------------
   // offset = floor((2*step*mag*2^30 + root) / (2*root)), round half away from zero
   logic [NumW-1:0]  numx_in, numy_in;
   dv_type           n1_in;
   logic             n1_v_ff;
   dv_type           n1_ff;
   logic [DivW-1:0]  n1_remx_ff, n1_remy_ff;

   assign numx_in = {1'b0, sq_ctx.prodx, 31'd0} + {31'd0, sq_root};
   assign numy_in = {1'b0, sq_ctx.prody, 31'd0} + {31'd0, sq_root};

   always_comb begin
      n1_in.px   = sq_ctx.px;
      n1_in.py   = sq_ctx.py;
      n1_in.sx   = sq_ctx.sx;
      n1_in.sy   = sq_ctx.sy;
      n1_in.negx = sq_ctx.negx;
      n1_in.negy = sq_ctx.negy;
      n1_in.near = sq_ctx.near;
      n1_in.zero = (sq_root == '0) || (step_ff == '0);
      n1_in.d    = {sq_root[RootW-2:0], 1'b0};
      n1_in.lowx = numx_in[QuoW-1:0];
      n1_in.lowy = numy_in[QuoW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_v_ff <= 1'b0;
      end else if (front_en) begin
         n1_v_ff <= sq_v;
      end
   end

   // quotient fits in QuoW bits, so the top part starts below the divisor
   always_ff @(posedge clock) begin
      if (front_en) begin
         n1_ff      <= n1_in;
         n1_remx_ff <= {3'b000, numx_in[NumW-1:QuoW]};
         n1_remy_ff <= {3'b000, numy_in[NumW-1:QuoW]};
      end
   end

   // ---------------- restoring division, one quotient bit per stage ----------------
   logic             dv_v_ff    [QuoW];
   dv_type           dv_ff      [QuoW];
   logic [DivW-1:0]  dv_remx_ff [QuoW];
   logic [DivW-1:0]  dv_remy_ff [QuoW];
   logic [QuoW-1:0]  dv_quox_ff [QuoW];
   logic [QuoW-1:0]  dv_quoy_ff [QuoW];

   for (genvar j = 0; j < QuoW; j++) begin : g_div
      localparam int Bit = QuoW - 1 - j;
      logic            v_prev;
      dv_type          p_prev;
      logic [DivW-1:0] remx_prev, remy_prev;
      logic [QuoW-1:0] quox_prev, quoy_prev;
      logic [DivW:0]   rx, ry, dd, dfx, dfy;
      logic            gex, gey;

      if (j == 0) begin : g_first
         assign v_prev    = n1_v_ff;
         assign p_prev    = n1_ff;
         assign remx_prev = n1_remx_ff;
         assign remy_prev = n1_remy_ff;
         assign quox_prev = '0;
         assign quoy_prev = '0;
      end else begin : g_next
         assign v_prev    = dv_v_ff[j-1];
         assign p_prev    = dv_ff[j-1];
         assign remx_prev = dv_remx_ff[j-1];
         assign remy_prev = dv_remy_ff[j-1];
         assign quox_prev = dv_quox_ff[j-1];
         assign quoy_prev = dv_quoy_ff[j-1];
      end

      assign rx  = {remx_prev, p_prev.lowx[Bit]};
      assign ry  = {remy_prev, p_prev.lowy[Bit]};
      assign dd  = {1'b0, p_prev.d};
      assign dfx = rx - dd;
      assign dfy = ry - dd;
      assign gex = (rx >= dd);
      assign gey = (ry >= dd);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (front_en) begin
            dv_v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (front_en) begin
            dv_ff[j]      <= p_prev;
            dv_remx_ff[j] <= gex ? dfx[DivW-1:0] : rx[DivW-1:0];
            dv_remy_ff[j] <= gey ? dfy[DivW-1:0] : ry[DivW-1:0];
            dv_quox_ff[j] <= {quox_prev[QuoW-2:0], gex};
            dv_quoy_ff[j] <= {quoy_prev[QuoW-2:0], gey};
         end
      end
   end

   // ---------------- final 1: clamp and sign the offsets ----------------
   dv_type           dv_last;
   logic [QuoW-1:0]  quox_last, quoy_last;
   logic [MagW-1:0]  qcx, qcy;
   logic [OffW-1:0]  offx_in, offy_in;
   logic signed [CoordW-1:0] f1_px_ff, f1_py_ff, f1_sx_ff, f1_sy_ff;
   logic                     f1_near_ff;
   logic signed [OffW-1:0]   f1_offx_ff, f1_offy_ff;

   assign dv_last   = dv_ff[QuoW-1];
   assign quox_last = dv_quox_ff[QuoW-1];
   assign quoy_last = dv_quoy_ff[QuoW-1];

   // zero step or zero distance gives no offset
   always_comb begin
      if (dv_last.zero) begin
         qcx = '0;
         qcy = '0;
      end else begin
         qcx = (|quox_last[QuoW-1:MagW]) ? '1 : quox_last[MagW-1:0];
         qcy = (|quoy_last[QuoW-1:MagW]) ? '1 : quoy_last[MagW-1:0];
      end
      offx_in = dv_last.negx ? (OffW'(0) - {2'b00, qcx}) : {2'b00, qcx};
      offy_in = dv_last.negy ? (OffW'(0) - {2'b00, qcy}) : {2'b00, qcy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (front_en) begin
         f1_v_ff <= dv_v_ff[QuoW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         f1_px_ff   <= dv_last.px;
         f1_py_ff   <= dv_last.py;
         f1_sx_ff   <= dv_last.sx;
         f1_sy_ff   <= dv_last.sy;
         f1_near_ff <= dv_last.near;
         f1_offx_ff <= offx_in;
         f1_offy_ff <= offy_in;
      end
   end

   // ---------------- final 2: add, saturate, select; output register ----------------
   logic [CoordW+2:0]        sumx, sumy;
   logic signed [CoordW-1:0] satx, saty;
   logic signed [CoordW-1:0] rsp_x_ff, rsp_y_ff;
   logic                     rsp_clipped_ff;

   assign sumx = {{3{f1_px_ff[CoordW-1]}}, f1_px_ff} + {f1_offx_ff[OffW-1], f1_offx_ff};
   assign sumy = {{3{f1_py_ff[CoordW-1]}}, f1_py_ff} + {f1_offy_ff[OffW-1], f1_offy_ff};

   // top four bits all equal means the sum is in range
   always_comb begin
      if ((&sumx[CoordW+2:CoordW-1]) || !(|sumx[CoordW+2:CoordW-1])) begin
         satx = sumx[CoordW-1:0];
      end else begin
         satx = sumx[CoordW+2] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      end
      if ((&sumy[CoordW+2:CoordW-1]) || !(|sumy[CoordW+2:CoordW-1])) begin
         saty = sumy[CoordW-1:0];
      end else begin
         saty = sumy[CoordW+2] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_en) begin
         rsp_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_x_ff       <= f1_near_ff ? f1_sx_ff : satx;
         rsp_y_ff       <= f1_near_ff ? f1_sy_ff : saty;
         rsp_clipped_ff <= !f1_near_ff;
      end
   end

   assign rsp_ch.valid   = rsp_v_ff;
   assign rsp_ch.new_x   = rsp_x_ff;
   assign rsp_ch.new_y   = rsp_y_ff;
   assign rsp_ch.clipped = rsp_clipped_ff;

   // ---------------- assertions ----------------
   // a result beat only shows up after the last pipe stage held an item
   a_out_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(f1_v_ff))
      else $error("result beat without an item in the last stage");

   // a zero step never counts as near
   a_zero_step_clips: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && (step_ff == '0)) |-> rsp_clipped_ff)
      else $error("zero step gave an unclipped result");

   // quotient stays below 2^33 whenever the offset is used
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_v_ff[QuoW-1] && !dv_last.zero) |->
         (!quox_last[QuoW-1] && !quoy_last[QuoW-1]))
      else $error("offset quotient out of range");

endmodule
`default_nettype wire

// ----- tb/sv/tb_planar_steer_toward_sample.sv -----
// testbench for planar_steer_toward_sample: random and directed point pairs checked by a scoreboard
`timescale 1ns / 100ps
`default_nettype none

// expected result of one point pair
typedef struct {
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic               clipped;
} steer_result_type;

class steer_scoreboard;
   steer_result_type pending_q[$];
   logic [30:0]      step_len;
   int unsigned      error_count;

   function new();
      step_len    = 31'd1 << 16;
      error_count = 0;
   endfunction

   // floor of the square root of a 128-bit value
   function automatic logic [63:0] root128(logic [127:0] s);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      return r;
   endfunction

   // rounded offset step*mag/dist, sign applied, magnitude capped at 32 bits
   function automatic longint offset(logic [63:0] mag, bit neg, logic [63:0] droot);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      longint       q;
      if (droot == 0 || mag == 0 || step_len == 0) return 0;
      num = (({97'd0, step_len} * {64'd0, mag}) << 31) + {64'd0, droot};
      den = {63'd0, droot, 1'b0};
      quo = num / den;
      if (quo[63:0] > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      else q = longint'(quo[63:0]);
      return neg ? -q : q;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // accepted request beat: work out the steered point
   function void note(logic signed [31:0] px, logic signed [31:0] py,
                      logic signed [31:0] sx, logic signed [31:0] sy);
      longint           dx;
      longint           dy;
      logic [63:0]      adx;
      logic [63:0]      ady;
      logic [63:0]      st;
      logic [127:0]     sq;
      logic [63:0]      droot;
      bit               is_near;
      steer_result_type r;
      dx  = longint'(sx) - longint'(px);
      dy  = longint'(sy) - longint'(py);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      st  = {33'd0, step_len};
      is_near = 0;
      if (adx < st && ady < st) is_near = (adx * adx + ady * ady) < st * st;
      if (is_near) begin
         r.new_x   = sx;
         r.new_y   = sy;
         r.clipped = 1'b0;
      end else begin
         sq    = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
         droot = root128(sq << 60);
         r.new_x   = clamp32(longint'(px) + offset(adx, dx < 0, droot));
         r.new_y   = clamp32(longint'(py) + offset(ady, dy < 0, droot));
         r.clipped = 1'b1;
      end
      pending_q.insert(pending_q.size(), r);
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // accepted response beat: compare with the oldest expectation
   task check(logic signed [31:0] nx, logic signed [31:0] ny, logic clipped);
      steer_result_type r;
      longint           tol;
      if (pending_q.size() == 0) begin
         report("unexpected beat new_x", nx, 0);
         return;
      end
      r   = pending_q.pop_front();
      // the clipped path may round within two lsb
      tol = r.clipped ? 2 : 0;
      if (clipped !== r.clipped) report("clipped", clipped, r.clipped);
      if ($isunknown(nx) || longint'(nx) - longint'(r.new_x) > tol ||
          longint'(r.new_x) - longint'(nx) > tol) report("new_x", nx, r.new_x);
      if ($isunknown(ny) || longint'(ny) - longint'(r.new_y) > tol ||
          longint'(r.new_y) - longint'(ny) > tol) report("new_y", ny, r.new_y);
   endtask
endclass

module tb_planar_steer_toward_sample;
   import pst_pkg::*;

   localparam int LATENCY  = 106;
   localparam int WDOG_MAX = 6000;  // idle cycles before giving up
   localparam int PHASE_N  = 240;   // random beats per step setting (half of it for two settings)

   logic clock;
   logic reset;

   pst_req_if req_ch ();
   pst_rsp_if rsp_ch ();
   pst_csr_if csr_ch ();

   steer_scoreboard sb;

   bit long_hold;    // asks the receiver for one long stall
   int burst_left;   // beats left in the current sender burst

   planar_steer_toward_sample #(.COORD_FRAC_BITS(16)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: counts cycles with no handshake on any channel
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready) || reset) idle = 0;
         else idle++;
         if (idle >= WDOG_MAX) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver: checks accepted beats and stalls on a pattern of its own
   initial begin
      int hold;
      int open_left;
      hold      = 0;
      open_left = 20;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check(rsp_ch.new_x, rsp_ch.new_y, rsp_ch.clipped);
         if (long_hold) begin
            // long stall so the pipe fills and the input backs up
            long_hold = 0;
            hold      = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (open_left > 0) begin
            open_left--;
            rsp_ch.ready <= 1'b1;
         end else begin
            hold      = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            open_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 25);
            rsp_ch.ready <= (hold == 0);
         end
      end
   end

   // one request beat; valid stays high into the next beat within a burst
   task push_pair(logic signed [31:0] px, logic signed [31:0] py,
                  logic signed [31:0] sx, logic signed [31:0] sy);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.parent_x <= px;
      req_ch.parent_y <= py;
      req_ch.sample_x <= sx;
      req_ch.sample_y <= sy;
      do @(posedge clock); while (!req_ch.ready);
      sb.note(px, py, sx, sy);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 40);
         gap        = $urandom_range(0, 5);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task drain();
      req_ch.valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   // step register write, only with the pipe empty
   task write_step(logic [30:0] value);
      drain();
      csr_ch.valid       <= 1'b1;
      csr_ch.step_length <= value;
      do @(posedge clock); while (!csr_ch.ready);
      sb.step_len = value;
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // random pair: mostly samples near the step radius, some full range noise
   task random_pair();
      logic signed [31:0] px;
      logic signed [31:0] py;
      longint             s;
      longint             dx;
      longint             dy;
      int                 kind;
      px   = $urandom;
      py   = $urandom;
      s    = sb.step_len == 0 ? 16 : sb.step_len;
      kind = $urandom_range(0, 9);
      dx   = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (4 * s + 1) - 2 * s;
      dy   = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (4 * s + 1) - 2 * s;
      case (kind)
         0, 1: push_pair($urandom, $urandom, $urandom, $urandom);
         2: begin
            // corners of the coordinate range
            push_pair($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                      $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                      $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                      $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
         end
         3: push_pair(px, py, px, py);
         4: begin
            // exactly one step along an axis
            if ($urandom_range(0, 1)) push_pair(px, py, sat(px + ($urandom_range(0, 1) ? s : -s)), py);
            else push_pair(px, py, px, sat(py + ($urandom_range(0, 1) ? s : -s)));
         end
         default: push_pair(px, py, sat(px + dx), sat(py + dy));
      endcase
   endtask

   task random_phase(int n);
      repeat (n) random_pair();
   endtask

   initial begin
      sb = new();
      long_hold  = 0;
      burst_left = 0;
      reset = 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.parent_x <= '0;
      req_ch.parent_y <= '0;
      req_ch.sample_x <= '0;
      req_ch.sample_y <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.step_length <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats at the reset step of 1.0
      push_pair(0, 0, 0, 0);                                  // coincident points
      push_pair(0, 0, 32'sh0001_0000, 0);                     // distance equals step
      push_pair(0, 0, 0, -32'sh0001_0000);
      push_pair(0, 0, 32'sh0000_9999, 32'sh0000_3333);        // inside the step
      push_pair(0, 0, 32'sh0000_B505, 32'sh0000_B505);        // just past the step on a diagonal
      push_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      push_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
      push_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
      push_pair(32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      push_pair(-32'sd5, 32'sd7, -32'sd5, 32'sd7);
      push_pair(32'sh0123_4567, 32'sh89AB_CDEF, 32'shFEDC_BA98, 32'sh7654_3210);

      long_hold = 1;  // input keeps offering while the output is held off
      random_phase(PHASE_N);

      write_step(31'd1);  // smallest legal step
      push_pair(0, 0, 1, 0);
      push_pair(0, 0, 0, 0);
      push_pair(0, 0, 3, 4);
      random_phase(PHASE_N);

      write_step(31'h7FFF_FFFF);  // largest step
      push_pair(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0);
      push_pair(0, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
      push_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      random_phase(PHASE_N);

      write_step(31'd0);  // zero step: parent returned, always clipped
      push_pair(32'sh0000_1000, -32'sh0000_2000, 32'sh0000_1000, -32'sh0000_2000);
      push_pair(32'sh0000_1000, 32'sh0000_2000, 32'sh7000_0000, 32'sh8000_0000);
      random_phase(PHASE_N / 2);

      write_step(31'd5 << 16);  // 3-4-5 triangle lands exactly on the step
      push_pair(0, 0, 32'sd3 << 16, 32'sd4 << 16);
      push_pair(32'sd3 << 16, 32'sd4 << 16, 0, 0);
      random_phase(PHASE_N);

      write_step(31'($urandom_range(16, 1 << 20)));
      random_phase(PHASE_N);

      write_step(31'($urandom_range(1, 32'h7FFF_FFFF)));
      random_phase(PHASE_N / 2);

      drain();
      repeat (LATENCY + 20) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_q.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/pst_pkg.sv
rtl/pst_ifs.sv
rtl/pst_isqrt.sv
rtl/planar_steer_toward_sample.sv
tb/sv/tb_planar_steer_toward_sample.sv
